FILE: rtl/sflpq_pkg.sv
`timescale 1ns / 1ps

package sflpq_pkg;

    // Default sizing of the queue.
    localparam int CAPACITY_DEFAULT = 16;
    localparam int LEVELS_DEFAULT   = 4;

    // Field widths of the request and result ports.
    localparam int REQ_W    = 2;
    localparam int PRIO_W   = 3;
    localparam int AGE_W    = 7;
    localparam int REF_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int WORD_W   = AGE_W + REF_W;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_pop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_hit;
    } stat_t;

endpackage

FILE: rtl/sflpq_ctrl.sv
`timescale 1ns / 1ps

module sflpq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sflpq_pkg::stat_t stat,
    output sflpq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.load_pop = 1'b0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    // A pop that finds an entry goes through S_READ for the memory read.
                    state_next = stat.pop_hit ? S_READ : S_RESP;
                end
            end
            S_READ:
            begin
                cmd.load_pop = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sflpq_datapath.sv
`timescale 1ns / 1ps

module sflpq_datapath
#(
    parameter int CAPACITY = sflpq_pkg::CAPACITY_DEFAULT,
    parameter int LEVELS   = sflpq_pkg::LEVELS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  sflpq_pkg::cmd_t                cmd,
    output sflpq_pkg::stat_t               stat,
    input  logic [sflpq_pkg::REQ_W-1:0]    req_type,
    input  logic [sflpq_pkg::PRIO_W-1:0]   priority_req,
    input  logic [sflpq_pkg::AGE_W-1:0]    age,
    input  logic [sflpq_pkg::REF_W-1:0]    payload_ref,
    output logic [sflpq_pkg::STATUS_W-1:0] status,
    output logic                           popped_valid,
    output logic [sflpq_pkg::PRIO_W-1:0]   popped_priority,
    output logic [sflpq_pkg::AGE_W-1:0]    popped_age,
    output logic [sflpq_pkg::REF_W-1:0]    popped_ref,
    output logic [sflpq_pkg::OCC_W-1:0]    occupancy
);

    localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int FW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = LEVELS * CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = sflpq_pkg::WORD_W;

    logic [PW-1:0] rd_ptr_reg  [LEVELS];
    logic [PW-1:0] rd_ptr_next [LEVELS];
    logic [PW-1:0] wr_ptr_reg  [LEVELS];
    logic [PW-1:0] wr_ptr_next [LEVELS];
    logic [FW-1:0] fill_reg    [LEVELS];
    logic [FW-1:0] fill_next   [LEVELS];
    logic [FW-1:0] total_reg;
    logic [FW-1:0] total_next;
    logic [LW-1:0] pop_cls_reg;
    logic [LW-1:0] pop_cls_next;

    logic [sflpq_pkg::STATUS_W-1:0] status_reg;
    logic [sflpq_pkg::STATUS_W-1:0] status_next;
    logic                           pvalid_reg;
    logic                           pvalid_next;
    logic [sflpq_pkg::PRIO_W-1:0]   pprio_reg;
    logic [sflpq_pkg::PRIO_W-1:0]   pprio_next;
    logic [sflpq_pkg::AGE_W-1:0]    page_reg;
    logic [sflpq_pkg::AGE_W-1:0]    page_next;
    logic [sflpq_pkg::REF_W-1:0]    pref_reg;
    logic [sflpq_pkg::REF_W-1:0]    pref_next;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    logic [LW-1:0] cls_push;
    logic [LW-1:0] cls_pop;
    logic          found;
    logic          full;
    logic [31:0]   occ_wide;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (32'(p) >= CAPACITY - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    // Out-of-range classes clamp to the nearest valid class.
    always_comb
    begin
        if (priority_req == '0)
        begin
            cls_push = '0;
        end
        else if (32'(priority_req) > LEVELS)
        begin
            cls_push = LW'(LEVELS - 1);
        end
        else
        begin
            cls_push = LW'(priority_req - sflpq_pkg::PRIO_W'(1));
        end
    end

    // Most urgent class that holds an entry.
    always_comb
    begin
        found   = 1'b0;
        cls_pop = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                found   = 1'b1;
                cls_pop = LW'(i);
            end
        end
    end

    assign full         = (total_reg == FW'(CAPACITY));
    assign stat.pop_hit = (req_type == sflpq_pkg::REQ_POP) && found;
    assign waddr        = AW'(32'(cls_push) * CAPACITY + 32'(wr_ptr_reg[cls_push]));
    assign raddr        = AW'(32'(cls_pop) * CAPACITY + 32'(rd_ptr_reg[cls_pop]));

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        pop_cls_next = pop_cls_reg;
        status_next  = status_reg;
        pvalid_next  = pvalid_reg;
        pprio_next   = pprio_reg;
        page_next    = page_reg;
        pref_next    = pref_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        if (cmd.accept)
        begin
            status_next = sflpq_pkg::STS_OK;
            pvalid_next = 1'b0;
            pprio_next  = '0;
            page_next   = '0;
            pref_next   = '0;
            case (req_type)
                sflpq_pkg::REQ_PUSH:
                begin
                    if (full)
                    begin
                        status_next = sflpq_pkg::STS_FULL;
                    end
                    else
                    begin
                        mem_we                = 1'b1;
                        wr_ptr_next[cls_push] = ring_next(wr_ptr_reg[cls_push]);
                        fill_next[cls_push]   = fill_reg[cls_push] + FW'(1);
                        total_next            = total_reg + FW'(1);
                    end
                end
                sflpq_pkg::REQ_POP:
                begin
                    if (found)
                    begin
                        mem_re               = 1'b1;
                        rd_ptr_next[cls_pop] = ring_next(rd_ptr_reg[cls_pop]);
                        fill_next[cls_pop]   = fill_reg[cls_pop] - FW'(1);
                        total_next           = total_reg - FW'(1);
                        pop_cls_next         = cls_pop;
                    end
                    else
                    begin
                        status_next = sflpq_pkg::STS_EMPTY;
                    end
                end
                sflpq_pkg::REQ_CLEAR:
                begin
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        rd_ptr_next[i] = '0;
                        wr_ptr_next[i] = '0;
                        fill_next[i]   = '0;
                    end
                    total_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.load_pop)
        begin
            pvalid_next = 1'b1;
            pprio_next  = sflpq_pkg::PRIO_W'(32'(pop_cls_reg) + 1);
            page_next   = rdata_reg[WW-1:sflpq_pkg::REF_W];
            pref_next   = rdata_reg[sflpq_pkg::REF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_cls_reg <= pop_cls_next;
        status_reg  <= status_next;
        pvalid_reg  <= pvalid_next;
        pprio_reg   <= pprio_next;
        page_reg    <= page_next;
        pref_reg    <= pref_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= {age, payload_ref};
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign occ_wide        = 32'(total_reg);
    assign occupancy       = occ_wide[sflpq_pkg::OCC_W-1:0];
    assign status          = status_reg;
    assign popped_valid    = pvalid_reg;
    assign popped_priority = pprio_reg;
    assign popped_age      = page_reg;
    assign popped_ref      = pref_reg;

endmodule

FILE: rtl/stable_four_level_priority_queue.sv
`timescale 1ns / 1ps

// Priority queue of up to CAPACITY entries in LEVELS classes, class 1 the most
// urgent, first-in first-out within a class. Each request (push, pop or clear)
// gives one result with a status and the occupancy after the request. The
// block handles one request at a time. A push, clear or unknown request shows
// its result in the cycle after it is accepted. A pop that finds an entry goes
// through S_READ before its result shows, because the entry store is a memory
// with a registered read port that the pop must wait on. A further request is
// accepted in the cycle after its predecessor's result is taken. No clearing
// pass is needed after reset.
module stable_four_level_priority_queue
#(
    parameter int CAPACITY = sflpq_pkg::CAPACITY_DEFAULT,
    parameter int LEVELS   = sflpq_pkg::LEVELS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sflpq_pkg::REQ_W-1:0]    req_type,
    input  logic [sflpq_pkg::PRIO_W-1:0]   priority_req,
    input  logic [sflpq_pkg::AGE_W-1:0]    age,
    input  logic [sflpq_pkg::REF_W-1:0]    payload_ref,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sflpq_pkg::STATUS_W-1:0] status,
    output logic                           popped_valid,
    output logic [sflpq_pkg::PRIO_W-1:0]   popped_priority,
    output logic [sflpq_pkg::AGE_W-1:0]    popped_age,
    output logic [sflpq_pkg::REF_W-1:0]    popped_ref,
    output logic [sflpq_pkg::OCC_W-1:0]    occupancy
);

    sflpq_pkg::cmd_t  cmd;
    sflpq_pkg::stat_t stat;

    sflpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sflpq_datapath
    #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req_type),
        .priority_req    (priority_req),
        .age             (age),
        .payload_ref     (payload_ref),
        .status          (status),
        .popped_valid    (popped_valid),
        .popped_priority (popped_priority),
        .popped_age      (popped_age),
        .popped_ref      (popped_ref),
        .occupancy       (occupancy)
    );

endmodule

FILE: rtl/sflpq_checker.sv
`timescale 1ns / 1ps

module sflpq_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [sflpq_pkg::STATUS_W-1:0] status,
    input logic                           popped_valid,
    input logic [sflpq_pkg::PRIO_W-1:0]   popped_priority,
    input logic [sflpq_pkg::OCC_W-1:0]    occupancy
);

    // One request at a time: no new request while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while a result is pending");

    // A popped entry always comes with an ok status and a real class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && popped_valid) |-> (status == sflpq_pkg::STS_OK
            && popped_priority != '0))
        else $error("popped entry with bad status or class");

    // A pop from an empty queue leaves the queue empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sflpq_pkg::STS_EMPTY) |-> (occupancy == '0
            && !popped_valid))
        else $error("empty status with entries held");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(occupancy)))
        else $error("stalled result changed");

endmodule

bind stable_four_level_priority_queue sflpq_checker u_sflpq_checker (.*);

FILE: bench/stable_four_level_priority_queue_test.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [sflpq_pkg::STATUS_W-1:0] status;
    logic                           popped_valid;
    logic [sflpq_pkg::PRIO_W-1:0]   popped_priority;
    logic [sflpq_pkg::AGE_W-1:0]    popped_age;
    logic [sflpq_pkg::REF_W-1:0]    popped_ref;
    logic [sflpq_pkg::OCC_W-1:0]    occupancy;
} queue_result_t;

class queue_scoreboard;
    localparam int LANES = sflpq_pkg::LEVELS_DEFAULT;
    localparam int DEPTH = sflpq_pkg::CAPACITY_DEFAULT;

    // One first-in first-out lane per urgency class, each word {age, ref}.
    logic [sflpq_pkg::WORD_W-1:0] class_lanes [LANES][$];
    int held;
    queue_result_t awaited_results[$];
    int errors;
    int pushes;
    int full_rejects;
    int pop_hits;
    int empty_pops;
    int clears;
    int unknown_reqs;
    int peak_held;

    function new();
        held = 0;
        errors = 0;
        pushes = 0;
        full_rejects = 0;
        pop_hits = 0;
        empty_pops = 0;
        clears = 0;
        unknown_reqs = 0;
        peak_held = 0;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function void note_request(logic [sflpq_pkg::REQ_W-1:0] kind,
                               logic [sflpq_pkg::PRIO_W-1:0] prio,
                               logic [sflpq_pkg::AGE_W-1:0] years,
                               logic [sflpq_pkg::REF_W-1:0] payload);
        queue_result_t r;
        int lane;
        int found;
        logic [sflpq_pkg::WORD_W-1:0] word;
        r = '0;
        found = -1;
        if (kind == sflpq_pkg::REQ_PUSH) begin
            if (held >= DEPTH) begin
                r.status = sflpq_pkg::STS_FULL;
                full_rejects++;
            end
            else begin
                // Out-of-range classes are clamped to the nearest valid one.
                if (prio == 0)
                    lane = 0;
                else if (prio > LANES)
                    lane = LANES - 1;
                else
                    lane = prio - 1;
                class_lanes[lane].push_back({years, payload});
                held++;
                pushes++;
                if (held > peak_held)
                    peak_held = held;
            end
        end
        else if (kind == sflpq_pkg::REQ_POP) begin
            for (int c = LANES - 1; c >= 0; c--)
                if (class_lanes[c].size() != 0)
                    found = c;
            if (found < 0) begin
                r.status = sflpq_pkg::STS_EMPTY;
                empty_pops++;
            end
            else begin
                word = class_lanes[found].pop_front();
                held--;
                pop_hits++;
                r.popped_valid = 1'b1;
                r.popped_priority = sflpq_pkg::PRIO_W'(found + 1);
                r.popped_age = word[sflpq_pkg::WORD_W-1:sflpq_pkg::REF_W];
                r.popped_ref = word[sflpq_pkg::REF_W-1:0];
            end
        end
        else if (kind == sflpq_pkg::REQ_CLEAR) begin
            for (int c = 0; c < LANES; c++)
                class_lanes[c].delete();
            held = 0;
            clears++;
        end
        else begin
            unknown_reqs++;
        end
        r.occupancy = sflpq_pkg::OCC_W'(held);
        awaited_results.push_back(r);
    endfunction

    function void flag_field(string field, logic [15:0] want, logic [15:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(queue_result_t got);
        queue_result_t want;
        if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t ns: result with nothing expected, got %0h", $time, got);
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status)
            flag_field("status", 16'(want.status), 16'(got.status));
        if (got.popped_valid !== want.popped_valid)
            flag_field("popped_valid", 16'(want.popped_valid), 16'(got.popped_valid));
        if (got.popped_priority !== want.popped_priority)
            flag_field("popped_priority", 16'(want.popped_priority),
                       16'(got.popped_priority));
        if (got.popped_age !== want.popped_age)
            flag_field("popped_age", 16'(want.popped_age), 16'(got.popped_age));
        if (got.popped_ref !== want.popped_ref)
            flag_field("popped_ref", want.popped_ref, got.popped_ref);
        if (got.occupancy !== want.occupancy)
            flag_field("occupancy", 16'(want.occupancy), 16'(got.occupancy));
    endfunction
endclass

module stable_four_level_priority_queue_test;

    localparam logic [sflpq_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int TARGET_REQUESTS = 1700;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [sflpq_pkg::REQ_W-1:0]    req_type = '0;
    logic [sflpq_pkg::PRIO_W-1:0]   priority_req = '0;
    logic [sflpq_pkg::AGE_W-1:0]    age = '0;
    logic [sflpq_pkg::REF_W-1:0]    payload_ref = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [sflpq_pkg::STATUS_W-1:0] status;
    logic                           popped_valid;
    logic [sflpq_pkg::PRIO_W-1:0]   popped_priority;
    logic [sflpq_pkg::AGE_W-1:0]    popped_age;
    logic [sflpq_pkg::REF_W-1:0]    popped_ref;
    logic [sflpq_pkg::OCC_W-1:0]    occupancy;

    queue_scoreboard board = new();
    bit no_idle = 1'b0;
    int sent = 0;

    stable_four_level_priority_queue dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .priority_req    (priority_req),
        .age             (age),
        .payload_ref     (payload_ref),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .popped_valid    (popped_valid),
        .popped_priority (popped_priority),
        .popped_age      (popped_age),
        .popped_ref      (popped_ref),
        .occupancy       (occupancy)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(input logic [sflpq_pkg::REQ_W-1:0] kind,
                                input logic [sflpq_pkg::PRIO_W-1:0] prio,
                                input logic [sflpq_pkg::AGE_W-1:0] years,
                                input logic [sflpq_pkg::REF_W-1:0] payload);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        priority_req <= prio;
        age <= years;
        payload_ref <= payload;
        do @(posedge clk); while (!in_ready);
        board.note_request(kind, prio, years, payload);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    // Mostly legal classes and ages; now and then the out-of-range codes.
    task automatic random_request(input int push_pct, input int pop_pct);
        int roll;
        logic [sflpq_pkg::REQ_W-1:0] kind;
        logic [sflpq_pkg::PRIO_W-1:0] prio;
        logic [sflpq_pkg::AGE_W-1:0] years;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            kind = sflpq_pkg::REQ_PUSH;
        else if (roll < push_pct + pop_pct)
            kind = sflpq_pkg::REQ_POP;
        else if (roll == 99)
            kind = sflpq_pkg::REQ_CLEAR;
        else
            kind = REQ_UNKNOWN;
        prio = sflpq_pkg::PRIO_W'(($urandom_range(0, 99) < 85) ?
                                  $urandom_range(1, 4) : $urandom_range(0, 7));
        years = sflpq_pkg::AGE_W'(($urandom_range(0, 99) < 85) ?
                                  $urandom_range(1, 110) : $urandom_range(0, 127));
        send_request(kind, prio, years, sflpq_pkg::REF_W'($urandom_range(0, 65535)));
    endtask

    // Result side: take results with random stalls between them.
    initial
    begin
        int stall;
        queue_result_t got;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {status, popped_valid, popped_priority, popped_age, popped_ref,
                       occupancy};
                board.check_result(got);
                stall = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int phase_len;
        int mode;
        int phase_count;
        phase_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(sflpq_pkg::REQ_POP, 3'd1, 7'd1, 16'h0000);
        send_request(REQ_UNKNOWN, 3'd7, 7'd127, 16'hffff);
        send_request(sflpq_pkg::REQ_PUSH, 3'd0, 7'd0, 16'h0000);
        send_request(sflpq_pkg::REQ_PUSH, 3'd7, 7'd127, 16'hffff);
        send_request(sflpq_pkg::REQ_PUSH, 3'd4, 7'd110, 16'h8000);
        send_request(sflpq_pkg::REQ_PUSH, 3'd5, 7'd1, 16'h0001);
        send_request(sflpq_pkg::REQ_PUSH, 3'd3, 7'd64, 16'h1234);
        send_request(sflpq_pkg::REQ_PUSH, 3'd2, 7'd63, 16'h7fff);
        send_request(sflpq_pkg::REQ_PUSH, 3'd1, 7'd5, 16'haaaa);
        send_request(sflpq_pkg::REQ_PUSH, 3'd6, 7'd42, 16'h5555);
        repeat (4) send_request(sflpq_pkg::REQ_POP, 3'd2, 7'd9, 16'h0f0f);
        send_request(sflpq_pkg::REQ_CLEAR, 3'd4, 7'd100, 16'hf0f0);
        send_request(sflpq_pkg::REQ_POP, 3'd1, 7'd1, 16'h00ff);
        send_request(sflpq_pkg::REQ_PUSH, 3'd2, 7'd33, 16'hc3c3);
        send_request(sflpq_pkg::REQ_POP, 3'd3, 7'd3, 16'h3c3c);
        wait_drained();

        // Phases alternate between filling, draining and a balanced mix, so the
        // queue swings between empty and full many times.
        while (sent < TARGET_REQUESTS)
        begin
            phase_len = $urandom_range(20, 80);
            mode = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                case (mode)
                    0: random_request(72, 25);
                    1: random_request(25, 72);
                    default: random_request(49, 48);
                endcase
            end
            phase_count++;
            if (phase_count % 5 == 0)
                wait_drained();
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d requests: %0d pushes, %0d full rejects, %0d pops, %0d empty pops,",
                 sent, board.pushes, board.full_rejects, board.pop_hits, board.empty_pops);
        $display("%0d clears, %0d unknown requests, peak occupancy %0d.",
                 board.clears, board.unknown_reqs, board.peak_held);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
